// ===== rtl/lookat_view_matrix_macros.svh =====
// Assertion shorthands for the look-at block checkers.
`ifndef LOOKAT_VIEW_MATRIX_MACROS_SVH
`define LOOKAT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication, disabled in reset
`define LVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lvm_pkg;

	localparam int IN_DW = 288;
	localparam int OUT_DW = 128;
	localparam int USER_W = 3;

	// normalizer formats
	localparam int MW = 30;            // justified magnitude bits
	localparam int NW = 2 * MW + 2;    // sum of squares
	localparam int RW = MW + 1;        // root bits
	localparam int NR = MW + 1;        // root steps
	localparam int QB = 17;            // quotient bits
	localparam int QW = QB + 1;        // signed unit component
	localparam int NNW = MW + QB + 1;  // dividend
	localparam int DW = RW + 1;        // divisor

	localparam logic [1:0] ROW_SIDE = 2'd0;
	localparam logic [1:0] ROW_UP = 2'd1;
	localparam logic [1:0] ROW_FWD = 2'd2;
	localparam logic [1:0] ROW_LAST = 2'd3;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
	localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

	typedef struct packed {
		logic [31:0] c3;
		logic [31:0] c2;
		logic [31:0] c1;
		logic [31:0] c0;
	} row_t;

	typedef struct packed {
		row_t r0;
		row_t r1;
		row_t r2;
		logic degen;
	} mat_t;

	// shift right 16, half away from zero
	function automatic logic signed [39:0] rnd16(input logic signed [55:0] v);
		logic [55:0] m;
		logic [55:0] r;
		logic signed [39:0] rv;
		m = v[55] ? 56'(-v) : 56'(v);
		r = (m + 56'd32768) >> 16;
		rv = 40'(r);
		return v[55] ? -rv : rv;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [39:0] v);
		if (v > SAT_HI) begin
			return 32'h7FFF_FFFF;
		end else if (v < SAT_LO) begin
			return 32'h8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lookat_view_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port    Side  Carries
// s_*     in    eye, target, up: 9 x 32-bit Q16.16
// m_*     out   one matrix row per transaction, row 0 to 3, tlast on row 3
//
// A matrix enters on one input transaction; its four rows leave on four
// transactions, so the row output sets the sustained rate. First row is
// offered once the matrix has passed every stage and been loaded into the row
// register; the two square root and divide chains take 59 stages each.
// Reset clears the valid bits and the row counter only. Once a matrix waits in
// the last stage behind a busy or stalled output, every stage freezes.

module lookat_view_matrix
	import lvm_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire  [IN_DW-1:0]   s_tdata,   // eye_x, eye_y, eye_z, target_x..z, up_x..z
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [OUT_DW-1:0]  m_tdata,   // col_zero, col_one, col_two, col_three
	output logic [USER_W-1:0]  m_tuser,   // row_index[1:0], degenerate
	output logic               m_tlast
);

	localparam int DIFW = 33;
	localparam int CRW = 50;
	localparam int SB1 = 192;
	localparam int SB2 = 3 * QW + 97;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [31:0] eye_s1 [0:2];
	logic signed [31:0] up_s1 [0:2];
	logic signed [DIFW-1:0] diff_s1 [0:2];
	logic [3*DIFW-1:0] diff_p;
	logic [SB1-1:0] sb1;

	logic n1_v, n1_z;
	logic [3*QW-1:0] n1_vec;
	logic [SB1-1:0] n1_sb;
	logic signed [QW-1:0] fwd_n1 [0:2];
	logic signed [31:0] eye_n1 [0:2];
	logic signed [31:0] up_n1 [0:2];

	logic signed [CRW-1:0] pc_s2 [0:5];
	logic signed [31:0] eye_s2 [0:2];
	logic signed [QW-1:0] fwd_s2 [0:2];
	logic dg_s2;

	logic signed [CRW-1:0] cr_s3 [0:2];
	logic signed [31:0] eye_s3 [0:2];
	logic signed [QW-1:0] fwd_s3 [0:2];
	logic dg_s3;
	logic [3*CRW-1:0] cr_p;
	logic [SB2-1:0] sb2;

	logic n2_v, n2_z;
	logic [3*QW-1:0] n2_vec;
	logic [SB2-1:0] n2_sb;
	logic signed [QW-1:0] side_n2 [0:2];
	logic signed [QW-1:0] fwd_n2 [0:2];
	logic signed [31:0] eye_n2 [0:2];

	logic signed [2*QW-1:0] uf_s4 [0:5];
	logic signed [CRW-1:0] ps_s4 [0:2];
	logic signed [CRW-1:0] pf_s4 [0:2];
	logic signed [QW-1:0] side_s4 [0:2];
	logic signed [QW-1:0] fwd_s4 [0:2];
	logic signed [31:0] eye_s4 [0:2];
	logic dg_s4;

	logic signed [2*QW:0] uw_s5 [0:2];
	logic signed [51:0] ds_s5, df_s5;
	logic signed [QW-1:0] side_s5 [0:2];
	logic signed [QW-1:0] fwd_s5 [0:2];
	logic signed [31:0] eye_s5 [0:2];
	logic dg_s5;

	logic signed [18:0] upw_s6 [0:2];
	logic [31:0] ts_s6, tf_s6;
	logic signed [QW-1:0] side_s6 [0:2];
	logic signed [QW-1:0] nf_s6 [0:2];
	logic signed [31:0] eye_s6 [0:2];
	logic dg_s6;

	logic signed [50:0] pu_s7 [0:2];
	logic signed [18:0] upw_s7 [0:2];
	logic [31:0] ts_s7, tf_s7;
	logic signed [QW-1:0] side_s7 [0:2];
	logic signed [QW-1:0] nf_s7 [0:2];
	logic dg_s7;

	logic signed [52:0] du_s8;
	logic signed [18:0] upw_s8 [0:2];
	logic [31:0] ts_s8, tf_s8;
	logic signed [QW-1:0] side_s8 [0:2];
	logic signed [QW-1:0] nf_s8 [0:2];
	logic dg_s8;

	mat_t item_s9;

	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= n1_v;
			v_s3 <= v_s2;
			v_s4 <= n2_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// target - eye
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				eye_s1[i] <= s_tdata[32*i +: 32];
				up_s1[i] <= s_tdata[32*(6+i) +: 32];
				diff_s1[i] <= DIFW'(signed'(s_tdata[32*(3+i) +: 32])) -
					DIFW'(signed'(s_tdata[32*i +: 32]));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_p[DIFW*i +: DIFW] = diff_s1[i];
			sb1[32*i +: 32] = eye_s1[i];
			sb1[96+32*i +: 32] = up_s1[i];
		end
	end

	lvm_norm #(.W(DIFW), .SB(SB1)) u_norm_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.in_vec    (diff_p),
		.in_sb     (sb1),
		.out_valid (n1_v),
		.out_vec   (n1_vec),
		.out_zero  (n1_z),
		.out_sb    (n1_sb)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fwd_n1[i] = n1_vec[QW*i +: QW];
			eye_n1[i] = n1_sb[32*i +: 32];
			up_n1[i] = n1_sb[96+32*i +: 32];
		end
	end

	// cross(forward, up), exact
	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s2[0] <= fwd_n1[1] * up_n1[2];
			pc_s2[1] <= fwd_n1[2] * up_n1[1];
			pc_s2[2] <= fwd_n1[2] * up_n1[0];
			pc_s2[3] <= fwd_n1[0] * up_n1[2];
			pc_s2[4] <= fwd_n1[0] * up_n1[1];
			pc_s2[5] <= fwd_n1[1] * up_n1[0];
			eye_s2 <= eye_n1;
			fwd_s2 <= fwd_n1;
			dg_s2 <= n1_z;

			cr_s3[0] <= pc_s2[0] - pc_s2[1];
			cr_s3[1] <= pc_s2[2] - pc_s2[3];
			cr_s3[2] <= pc_s2[4] - pc_s2[5];
			eye_s3 <= eye_s2;
			fwd_s3 <= fwd_s2;
			dg_s3 <= dg_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr_p[CRW*i +: CRW] = cr_s3[i];
			sb2[32*i +: 32] = eye_s3[i];
			sb2[96+QW*i +: QW] = fwd_s3[i];
		end
		sb2[SB2-1] = dg_s3;
	end

	lvm_norm #(.W(CRW), .SB(SB2)) u_norm_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.in_vec    (cr_p),
		.in_sb     (sb2),
		.out_valid (n2_v),
		.out_vec   (n2_vec),
		.out_zero  (n2_z),
		.out_sb    (n2_sb)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_n2[i] = n2_vec[QW*i +: QW];
			eye_n2[i] = n2_sb[32*i +: 32];
			fwd_n2[i] = n2_sb[96+QW*i +: QW];
		end
	end

	// upward products and dot products with eye
	always_ff @(posedge clk) begin
		if (adv) begin
			uf_s4[0] <= side_n2[1] * fwd_n2[2];
			uf_s4[1] <= side_n2[2] * fwd_n2[1];
			uf_s4[2] <= side_n2[2] * fwd_n2[0];
			uf_s4[3] <= side_n2[0] * fwd_n2[2];
			uf_s4[4] <= side_n2[0] * fwd_n2[1];
			uf_s4[5] <= side_n2[1] * fwd_n2[0];
			for (int i = 0; i < 3; i++) begin
				ps_s4[i] <= side_n2[i] * eye_n2[i];
				pf_s4[i] <= fwd_n2[i] * eye_n2[i];
			end
			side_s4 <= side_n2;
			fwd_s4 <= fwd_n2;
			eye_s4 <= eye_n2;
			dg_s4 <= n2_sb[SB2-1] | n2_z;

			uw_s5[0] <= uf_s4[0] - uf_s4[1];
			uw_s5[1] <= uf_s4[2] - uf_s4[3];
			uw_s5[2] <= uf_s4[4] - uf_s4[5];
			ds_s5 <= ps_s4[0] + ps_s4[1] + ps_s4[2];
			df_s5 <= pf_s4[0] + pf_s4[1] + pf_s4[2];
			side_s5 <= side_s4;
			fwd_s5 <= fwd_s4;
			eye_s5 <= eye_s4;
			dg_s5 <= dg_s4;

			// -forward row: -(round(-d)) is round(d)
			for (int i = 0; i < 3; i++) begin
				upw_s6[i] <= 19'(rnd16(56'(uw_s5[i])));
				nf_s6[i] <= -fwd_s5[i];
			end
			ts_s6 <= sat32(-rnd16(56'(ds_s5)));
			tf_s6 <= sat32(rnd16(56'(df_s5)));
			side_s6 <= side_s5;
			eye_s6 <= eye_s5;
			dg_s6 <= dg_s5;

			for (int i = 0; i < 3; i++) begin
				pu_s7[i] <= upw_s6[i] * eye_s6[i];
			end
			upw_s7 <= upw_s6;
			ts_s7 <= ts_s6;
			tf_s7 <= tf_s6;
			side_s7 <= side_s6;
			nf_s7 <= nf_s6;
			dg_s7 <= dg_s6;

			du_s8 <= pu_s7[0] + pu_s7[1] + pu_s7[2];
			upw_s8 <= upw_s7;
			ts_s8 <= ts_s7;
			tf_s8 <= tf_s7;
			side_s8 <= side_s7;
			nf_s8 <= nf_s7;
			dg_s8 <= dg_s7;

			item_s9.r0.c0 <= 32'(side_s8[0]);
			item_s9.r0.c1 <= 32'(side_s8[1]);
			item_s9.r0.c2 <= 32'(side_s8[2]);
			item_s9.r0.c3 <= ts_s8;
			item_s9.r1.c0 <= 32'(upw_s8[0]);
			item_s9.r1.c1 <= 32'(upw_s8[1]);
			item_s9.r1.c2 <= 32'(upw_s8[2]);
			item_s9.r1.c3 <= sat32(-rnd16(56'(du_s8)));
			item_s9.r2.c0 <= 32'(nf_s8[0]);
			item_s9.r2.c1 <= 32'(nf_s8[1]);
			item_s9.r2.c2 <= 32'(nf_s8[2]);
			item_s9.r2.c3 <= tf_s8;
			item_s9.degen <= dg_s8;
		end
	end

	lvm_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_item  (item_s9),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/lvm_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lvm_norm
	import lvm_pkg::*;
#(
	parameter int W = 33,
	parameter int SB = 1
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  wire              in_valid,
	input  wire  [3*W-1:0]   in_vec,
	input  wire  [SB-1:0]    in_sb,
	output logic             out_valid,
	output logic [3*QW-1:0]  out_vec,
	output logic             out_zero,
	output logic [SB-1:0]    out_sb
);

	localparam int LV = $clog2(W);
	localparam int LAT = LV + NR + QB + 5;
	localparam int CW = SB + 4;

	logic [W-1:0] mag [0:2];
	logic [2:0] neg;
	logic zero;

	logic [LAT-1:0] vld_s;
	logic [CW-1:0] ctl_s [0:LAT-1];
	logic [W-1:0] jm_s [0:LV][0:2];
	logic [2*MW-1:0] sq_s [0:2];
	logic [MW-1:0] mc_s [0:NR+1][0:2];
	logic [NW-1:0] rn_n_s [0:NR];
	logic [NW-1:0] rn_r_s [0:NR];
	logic [NNW-1:0] dv_rem_s [0:QB][0:2];
	logic [QB-1:0] dv_q_s [0:QB][0:2];
	logic [DW-1:0] dv_d_s [0:QB];
	logic [QW-1:0] ov_s [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i] = in_vec[W*i + W-1];
			mag[i] = neg[i] ? W'(-in_vec[W*i +: W]) : in_vec[W*i +: W];
		end
		zero = (in_vec == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0] <= {zero, neg, in_sb};
			for (int t = 1; t < LAT; t++) begin
				ctl_s[t] <= ctl_s[t-1];
			end
			for (int i = 0; i < 3; i++) begin
				jm_s[0][i] <= mag[i];
			end
		end
	end

	// left-justify all three by the common leading-zero count
	for (genvar k = 1; k <= LV; k++) begin : g_just
		localparam int SH = 1 << (LV - k);
		logic [W-1:0] orv;
		logic hi_zero;
		assign orv = jm_s[k-1][0] | jm_s[k-1][1] | jm_s[k-1][2];
		assign hi_zero = (orv[W-1 -: SH] == '0);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					jm_s[k][i] <= hi_zero ? (jm_s[k-1][i] << SH) : jm_s[k-1][i];
				end
			end
		end
	end

	// squares, then sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mc_s[0][i] <= jm_s[LV][i][W-1 -: MW];
				sq_s[i] <= jm_s[LV][i][W-1 -: MW] * jm_s[LV][i][W-1 -: MW];
				mc_s[1][i] <= mc_s[0][i];
			end
			rn_n_s[0] <= NW'(sq_s[0]) + NW'(sq_s[1]) + NW'(sq_s[2]);
			rn_r_s[0] <= '0;
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 1; k <= NR; k++) begin : g_root
		localparam logic [NW-1:0] BIT = NW'(1) << (2 * (NR - k));
		logic [NW-1:0] t;
		logic ge;
		assign t = rn_r_s[k-1] + BIT;
		assign ge = (rn_n_s[k-1] >= t);
		always_ff @(posedge clk) begin
			if (en) begin
				rn_n_s[k] <= ge ? (rn_n_s[k-1] - t) : rn_n_s[k-1];
				rn_r_s[k] <= ge ? ((rn_r_s[k-1] >> 1) + BIT) : (rn_r_s[k-1] >> 1);
				for (int i = 0; i < 3; i++) begin
					mc_s[k+1][i] <= mc_s[k][i];
				end
			end
		end
	end

	// q = (m * 2^17 + len) / (2 * len)
	always_ff @(posedge clk) begin
		if (en) begin
			dv_d_s[0] <= {rn_r_s[NR][RW-1:0], 1'b0};
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= NNW'({mc_s[NR+1][i], {QB{1'b0}}}) +
					NNW'(rn_r_s[NR][RW-1:0]);
				dv_q_s[0][i] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		localparam int SHB = QB - k;
		logic [NNW:0] dsh;
		logic [2:0] ge;
		assign dsh = (NNW + 1)'(dv_d_s[k-1]) << SHB;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = ({1'b0, dv_rem_s[k-1][i]} >= dsh);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_d_s[k] <= dv_d_s[k-1];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k][i] <= ge[i] ? (dv_rem_s[k-1][i] - dsh[NNW-1:0]) :
						dv_rem_s[k-1][i];
					dv_q_s[k][i] <= dv_q_s[k-1][i] | (QB'(ge[i]) << SHB);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (ctl_s[LAT-2][CW-1]) begin
					ov_s[i] <= '0;
				end else if (ctl_s[LAT-2][SB+i]) begin
					ov_s[i] <= -QW'(dv_q_s[QB][i]);
				end else begin
					ov_s[i] <= QW'(dv_q_s[QB][i]);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_vec[QW*i +: QW] = ov_s[i];
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign out_zero = ctl_s[LAT-1][CW-1];
	assign out_sb = ctl_s[LAT-1][SB-1:0];

endmodule

`default_nettype wire

// ===== rtl/lvm_serial.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lvm_serial
	import lvm_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire  mat_t         in_item,
	output logic               adv,
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [OUT_DW-1:0]  m_tdata,
	output logic [USER_W-1:0]  m_tuser,
	output logic               m_tlast
);

	logic busy_q;
	logic [1:0] row_q;
	mat_t item_q;
	logic take;
	logic load;

	assign take = busy_q && m_tready;
	assign load = in_valid && (!busy_q || (take && row_q == ROW_LAST));
	assign adv = !in_valid || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q <= ROW_SIDE;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q <= ROW_SIDE;
		end else if (take) begin
			if (row_q == ROW_LAST) begin
				busy_q <= 1'b0;
			end
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= in_item;
		end
	end

	always_comb begin
		unique case (row_q)
			ROW_SIDE: m_tdata = item_q.r0;
			ROW_UP:   m_tdata = item_q.r1;
			ROW_FWD:  m_tdata = item_q.r2;
			ROW_LAST: m_tdata = {ONE_Q16, 96'd0};
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tuser = {item_q.degen, row_q};
	assign m_tlast = (row_q == ROW_LAST);

endmodule

`default_nettype wire

// ===== rtl/lvm_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lookat_view_matrix_macros.svh"

module lvm_check
	import lvm_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                m_tvalid,
	input wire                m_tready,
	input wire [OUT_DW-1:0]   m_tdata,
	input wire [USER_W-1:0]   m_tuser,
	input wire                m_tlast
);

	`LVM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")
	`LVM_ASSERT_NEXT(a_row_seq, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1) && (m_tuser[2] == $past(m_tuser[2])), "rows of one matrix out of order")
	`LVM_ASSERT_NOW(a_last_row, clk, arst_n, m_tvalid, m_tlast == (m_tuser[1:0] == ROW_LAST), "tlast not on row 3")
	`LVM_ASSERT_NOW(a_row3_const, clk, arst_n, m_tvalid && m_tlast, (m_tdata[127:96] == ONE_Q16) && (m_tdata[95:0] == 96'd0), "row 3 not 0,0,0,1")

endmodule

bind lookat_view_matrix lvm_check u_lvm_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
